// ===== design/cwm_pkg.sv =====
`timescale 1ns / 1ps

package cwm_pkg;

  localparam int unsigned COORD_W = 10;
  localparam int unsigned DET_W   = 4;
  localparam int unsigned RAW_W   = 32;
  localparam int unsigned HALF_W  = 16;
  localparam int unsigned PADDR_W = 3;
  localparam int unsigned PDATA_W = 32;

  localparam logic [COORD_W-1:0] MAX_X_RST = 10'd640;
  localparam logic [COORD_W-1:0] MAX_Y_RST = 10'd480;

  // register select is paddr[2]
  localparam logic REG_MAX_X = 1'b0;
  localparam logic REG_MAX_Y = 1'b1;

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_WRITE = 5'b00010,
    ST_LOAD  = 5'b00100,
    ST_SORT  = 5'b01000,
    ST_DONE  = 5'b10000
  } state_e;

  typedef struct packed {
    logic start;
    logic write;
    logic rd_issue;
    logic rd_cap;
    logic sort;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic det_ok;
  } sts_t;

endpackage

// ===== design/coord_window_median_core.sv =====
`timescale 1ns / 1ps
// Per-detector sliding-window median of x/y coordinates.
// Input channel (in_valid_i/in_ready_o): one beat carries a detector index,
// a raw word (y in bits 31..16, x in bits 15..0) and a frame-end flag.
// Output channel (out_valid_o/out_ready_i): one beat per input beat with the
// detector, median x, median y and whether the sample was stored.
// APB port: max_x at address 0, max_y at address 4; write only while idle.
// One item is in work at a time. For a present detector an in-range sample is
// stored, the ring is read out of the history memory (one port) and sorted
// with WINDOW odd-even compare-exchange passes before the result is loaded
// into the output register; for a detector index at or beyond DETECTORS the
// read and sort are skipped and both medians are zero. The next beat is taken
// once the result is loaded.
// The output register holds a finished result while a new beat is taken; if
// the receiver stalls and that register is full, the next result waits.
// Reset clears the ring index and all history (per-entry valid bits, so the
// block is ready at once), and loads max_x=640, max_y=480.
module coord_window_median_core #(
  parameter int unsigned WINDOW    = 8,
  parameter int unsigned DETECTORS = 4
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic [cwm_pkg::DET_W-1:0]           detector_i,
  input  logic [cwm_pkg::RAW_W-1:0]           raw_word_i,
  input  logic                                frame_end_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic [cwm_pkg::DET_W-1:0]           out_detector_o,
  output logic [cwm_pkg::COORD_W-1:0]         median_x_o,
  output logic [cwm_pkg::COORD_W-1:0]         median_y_o,
  output logic                                accepted_o,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [cwm_pkg::PADDR_W-1:0]         paddr,
  input  logic [cwm_pkg::PDATA_W-1:0]         pwdata,
  output logic [cwm_pkg::PDATA_W-1:0]         prdata,
  output logic                                pready
);

  cwm_pkg::cmd_t               cmd;
  cwm_pkg::sts_t               sts;
  logic [cwm_pkg::COORD_W-1:0] max_x, max_y;

  cwm_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .max_x_o (max_x),
    .max_y_o (max_y)
  );

  cwm_ctrl #(
    .WINDOW (WINDOW)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  cwm_dpath #(
    .WINDOW    (WINDOW),
    .DETECTORS (DETECTORS)
  ) u_dpath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .max_x_i        (max_x),
    .max_y_i        (max_y),
    .detector_i     (detector_i),
    .raw_word_i     (raw_word_i),
    .frame_end_i    (frame_end_i),
    .out_detector_o (out_detector_o),
    .median_x_o     (median_x_o),
    .median_y_o     (median_y_o),
    .accepted_o     (accepted_o)
  );

endmodule

// ===== design/cwm_regs.sv =====
`timescale 1ns / 1ps

module cwm_regs (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [cwm_pkg::PADDR_W-1:0]         paddr,
  input  logic [cwm_pkg::PDATA_W-1:0]         pwdata,
  output logic [cwm_pkg::PDATA_W-1:0]         prdata,
  output logic                                pready,
  output logic [cwm_pkg::COORD_W-1:0]         max_x_o,
  output logic [cwm_pkg::COORD_W-1:0]         max_y_o
);

  logic [cwm_pkg::COORD_W-1:0] max_x_q, max_x_d;
  logic [cwm_pkg::COORD_W-1:0] max_y_q, max_y_d;
  logic                        wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite;

  always_comb begin
    max_x_d = max_x_q;
    max_y_d = max_y_q;
    if (wr_en) begin
      unique case (paddr[2])
        cwm_pkg::REG_MAX_X: max_x_d = pwdata[cwm_pkg::COORD_W-1:0];
        cwm_pkg::REG_MAX_Y: max_y_d = pwdata[cwm_pkg::COORD_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      cwm_pkg::REG_MAX_X: prdata = {{(cwm_pkg::PDATA_W-cwm_pkg::COORD_W){1'b0}}, max_x_q};
      cwm_pkg::REG_MAX_Y: prdata = {{(cwm_pkg::PDATA_W-cwm_pkg::COORD_W){1'b0}}, max_y_q};
      default:            prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_x_q <= cwm_pkg::MAX_X_RST;
      max_y_q <= cwm_pkg::MAX_Y_RST;
    end else begin
      max_x_q <= max_x_d;
      max_y_q <= max_y_d;
    end
  end

  assign max_x_o = max_x_q;
  assign max_y_o = max_y_q;

endmodule

// ===== design/cwm_ctrl.sv =====
`timescale 1ns / 1ps

module cwm_ctrl #(
  parameter int unsigned WINDOW = 8
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  input  cwm_pkg::sts_t sts_i,
  output cwm_pkg::cmd_t cmd_o
);

  localparam int unsigned CW = $clog2(WINDOW + 1);

  cwm_pkg::state_e state_q, state_d;
  logic [CW-1:0]   cnt_q, cnt_d;
  logic            out_valid_q, out_valid_d;

  always_comb begin
    state_d      = state_q;
    cnt_d        = cnt_q;
    cmd_o        = '0;
    unique case (state_q)
      cwm_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.start = 1'b1;
          state_d     = cwm_pkg::ST_WRITE;
        end
      end
      cwm_pkg::ST_WRITE: begin
        cmd_o.write = 1'b1;
        cnt_d       = '0;
        state_d     = sts_i.det_ok ? cwm_pkg::ST_LOAD : cwm_pkg::ST_DONE;
      end
      cwm_pkg::ST_LOAD: begin
        cmd_o.rd_issue = (cnt_q != CW'(WINDOW));
        cmd_o.rd_cap   = (cnt_q != '0);
        if (cnt_q == CW'(WINDOW)) begin
          cnt_d   = '0;
          state_d = cwm_pkg::ST_SORT;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      cwm_pkg::ST_SORT: begin
        cmd_o.sort = 1'b1;
        if (cnt_q == CW'(WINDOW - 1)) begin
          state_d = cwm_pkg::ST_DONE;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      cwm_pkg::ST_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.out_load = 1'b1;
          state_d        = cwm_pkg::ST_IDLE;
        end
      end
      default: state_d = cwm_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.out_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= cwm_pkg::ST_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_ready_o  = (state_q == cwm_pkg::ST_IDLE);
  assign out_valid_o = out_valid_q;

endmodule

// ===== design/cwm_dpath.sv =====
`timescale 1ns / 1ps

module cwm_dpath #(
  parameter int unsigned WINDOW    = 8,
  parameter int unsigned DETECTORS = 4
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  cwm_pkg::cmd_t               cmd_i,
  output cwm_pkg::sts_t               sts_o,
  input  logic [cwm_pkg::COORD_W-1:0] max_x_i,
  input  logic [cwm_pkg::COORD_W-1:0] max_y_i,
  input  logic [cwm_pkg::DET_W-1:0]   detector_i,
  input  logic [cwm_pkg::RAW_W-1:0]   raw_word_i,
  input  logic                        frame_end_i,
  output logic [cwm_pkg::DET_W-1:0]   out_detector_o,
  output logic [cwm_pkg::COORD_W-1:0] median_x_o,
  output logic [cwm_pkg::COORD_W-1:0] median_y_o,
  output logic                        accepted_o
);

  localparam int unsigned CW_  = cwm_pkg::COORD_W;
  localparam int unsigned DEPTH = WINDOW * DETECTORS;
  localparam int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned SW    = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int unsigned MID   = WINDOW / 2;
  localparam int unsigned LO    = (WINDOW > 1) ? (WINDOW / 2 - 1) : 0;
  localparam bit          EVEN  = ((WINDOW % 2) == 0);
  localparam logic [cwm_pkg::DET_W:0] DET_LIM = (cwm_pkg::DET_W + 1)'(DETECTORS);

  logic [2*CW_-1:0]         mem_q [DEPTH];
  logic [DEPTH-1:0]         vld_q;
  logic [2*CW_-1:0]         rd_data_q;
  logic                     rd_vld_q;

  logic [cwm_pkg::DET_W-1:0] det_q;
  logic [CW_-1:0]            x_q, y_q;
  logic                      frame_q;
  logic                      det_ok_q;
  logic                      acc_q;
  logic [SW-1:0]             slot_q;
  logic [SW-1:0]             rd_idx_q;
  logic                      phase_q;

  logic [CW_-1:0] work_x_q [WINDOW];
  logic [CW_-1:0] work_y_q [WINDOW];
  logic [CW_-1:0] sort_x   [WINDOW];
  logic [CW_-1:0] sort_y   [WINDOW];

  logic [cwm_pkg::HALF_W-1:0] raw_x, raw_y;
  logic                       in_range;
  logic                       det_ok;
  logic [AW-1:0]              base;
  logic [AW-1:0]              wr_addr, rd_addr;
  logic [CW_:0]               sum_x, sum_y;
  logic [CW_-1:0]             med_x, med_y;

  logic [cwm_pkg::DET_W-1:0] out_det_q;
  logic [CW_-1:0]            out_mx_q, out_my_q;
  logic                      out_acc_q;

  assign raw_x    = raw_word_i[cwm_pkg::HALF_W-1:0];
  assign raw_y    = raw_word_i[cwm_pkg::RAW_W-1:cwm_pkg::HALF_W];
  assign in_range = (raw_x <= {{(cwm_pkg::HALF_W-CW_){1'b0}}, max_x_i}) &&
                    (raw_y <= {{(cwm_pkg::HALF_W-CW_){1'b0}}, max_y_i});
  assign det_ok   = ({1'b0, detector_i} < DET_LIM);

  assign base    = AW'(det_q) * AW'(WINDOW);
  assign wr_addr = base + AW'(slot_q);
  assign rd_addr = base + AW'(rd_idx_q);

  assign sts_o.det_ok = det_ok_q;

  // capture item
  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      det_q    <= detector_i;
      x_q      <= raw_x[CW_-1:0];
      y_q      <= raw_y[CW_-1:0];
      frame_q  <= frame_end_i;
      det_ok_q <= det_ok;
      acc_q    <= det_ok & in_range;
    end
  end

  // history store
  always_ff @(posedge clk_i) begin
    if (cmd_i.write && acc_q) begin
      mem_q[wr_addr] <= {y_q, x_q};
    end
    if (cmd_i.rd_issue) begin
      rd_data_q <= mem_q[rd_addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q    <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      if (cmd_i.write && acc_q) begin
        vld_q[wr_addr] <= 1'b1;
      end
      if (cmd_i.rd_issue) begin
        rd_vld_q <= vld_q[rd_addr];
      end
    end
  end

  // odd-even transposition step
  always_comb begin
    for (int i = 0; i < WINDOW; i++) begin
      sort_x[i] = work_x_q[i];
      sort_y[i] = work_y_q[i];
    end
    for (int i = 0; i + 1 < WINDOW; i++) begin
      if (((i % 2) == 1) == phase_q) begin
        if (work_x_q[i] > work_x_q[i+1]) begin
          sort_x[i]   = work_x_q[i+1];
          sort_x[i+1] = work_x_q[i];
        end
        if (work_y_q[i] > work_y_q[i+1]) begin
          sort_y[i]   = work_y_q[i+1];
          sort_y[i+1] = work_y_q[i];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.rd_cap) begin
      for (int i = 0; i + 1 < WINDOW; i++) begin
        work_x_q[i] <= work_x_q[i+1];
        work_y_q[i] <= work_y_q[i+1];
      end
      work_x_q[WINDOW-1] <= rd_vld_q ? rd_data_q[CW_-1:0] : '0;
      work_y_q[WINDOW-1] <= rd_vld_q ? rd_data_q[2*CW_-1:CW_] : '0;
    end else if (cmd_i.sort) begin
      for (int i = 0; i < WINDOW; i++) begin
        work_x_q[i] <= sort_x[i];
        work_y_q[i] <= sort_y[i];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_q   <= '0;
      rd_idx_q <= '0;
      phase_q  <= 1'b0;
    end else begin
      if (cmd_i.start) begin
        rd_idx_q <= '0;
        phase_q  <= 1'b0;
      end else begin
        if (cmd_i.rd_issue) begin
          rd_idx_q <= rd_idx_q + 1'b1;
        end
        if (cmd_i.sort) begin
          phase_q <= ~phase_q;
        end
      end
      if (cmd_i.out_load && frame_q) begin
        slot_q <= (slot_q == SW'(WINDOW - 1)) ? '0 : slot_q + 1'b1;
      end
    end
  end

  assign sum_x = {1'b0, work_x_q[MID]} + {1'b0, work_x_q[LO]};
  assign sum_y = {1'b0, work_y_q[MID]} + {1'b0, work_y_q[LO]};
  assign med_x = EVEN ? sum_x[CW_:1] : work_x_q[MID];
  assign med_y = EVEN ? sum_y[CW_:1] : work_y_q[MID];

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_det_q <= det_q;
      out_mx_q  <= det_ok_q ? med_x : '0;
      out_my_q  <= det_ok_q ? med_y : '0;
      out_acc_q <= acc_q;
    end
  end

  assign out_detector_o = out_det_q;
  assign median_x_o     = out_mx_q;
  assign median_y_o     = out_my_q;
  assign accepted_o     = out_acc_q;

endmodule

// ===== design/cwm_checker.sv =====
`timescale 1ns / 1ps

module cwm_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        in_valid_i,
  input logic                        in_ready_o,
  input logic                        out_valid_o,
  input logic                        out_ready_i,
  input logic [cwm_pkg::DET_W-1:0]   out_detector_o,
  input logic [cwm_pkg::COORD_W-1:0] median_x_o,
  input logic [cwm_pkg::COORD_W-1:0] median_y_o,
  input logic                        accepted_o,
  input logic                        pready
);

  // stalled result beat holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_detector_o) &&
    $stable(median_x_o) && $stable(median_y_o) && $stable(accepted_o))
    else $error("stalled result beat changed");

  // one item in work at a time
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("input taken while an item is in work");

  // no result in the cycle right after an input beat
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !$rose(out_valid_o))
    else $error("result raised too early");

  assert property (@(posedge clk_i) disable iff (!rst_ni) pready)
    else $error("pready dropped");

endmodule

bind coord_window_median_core cwm_checker u_cwm_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_valid_i     (in_valid_i),
  .in_ready_o     (in_ready_o),
  .out_valid_o    (out_valid_o),
  .out_ready_i    (out_ready_i),
  .out_detector_o (out_detector_o),
  .median_x_o     (median_x_o),
  .median_y_o     (median_y_o),
  .accepted_o     (accepted_o),
  .pready         (pready)
);
